// ===== src/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch swipe classifier package
// Shared widths, screen constants, event kinds and gesture codes.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int TYPE_W      = 5;
   localparam int CODE_W      = 10;
   localparam int RAW_W       = 16;
   localparam int COORD_W     = 10;
   localparam int X_W         = 10;
   localparam int Y_W         = 9;
   localparam int THR_W       = 10;
   localparam int GEST_W      = 3;
   localparam int SPAN_W      = 17;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = RAW_W + COORD_W;
   localparam int TRIAL_W     = COORD_W + 1 + SPAN_W;

   localparam logic [COORD_W-1:0] SCREEN_WIDTH  = 10'd800;
   localparam logic [COORD_W-1:0] SCREEN_HEIGHT = 10'd480;
   localparam logic [SPAN_W-1:0]  RAW_X_SPAN    = 17'd1024;
   localparam logic [SPAN_W-1:0]  RAW_Y_SPAN    = 17'd600;

   localparam logic [RECIP_W-1:0] RECIP_X =
      RECIP_W'((64'(SCREEN_WIDTH) << RECIP_SHIFT) / 64'(RAW_X_SPAN));
   localparam logic [RECIP_W-1:0] RECIP_Y =
      RECIP_W'((64'(SCREEN_HEIGHT) << RECIP_SHIFT) / 64'(RAW_Y_SPAN));

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 10'd50;

   localparam logic [TYPE_W-1:0] EVT_KEY    = 5'd1;
   localparam logic [TYPE_W-1:0] EVT_ABS    = 5'd3;
   localparam logic [CODE_W-1:0] CODE_X     = 10'd0;
   localparam logic [CODE_W-1:0] CODE_Y     = 10'd1;
   localparam logic [CODE_W-1:0] CODE_TOUCH = 10'd330;
   localparam logic [RAW_W-1:0]  BTN_UP     = 16'd0;
   localparam logic [RAW_W-1:0]  BTN_DOWN   = 16'd1;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ABS_X,
      KIND_ABS_Y,
      KIND_DOWN,
      KIND_UP
   } kind_type;

   typedef enum logic [GEST_W-1:0] {
      GEST_UP    = 3'd0,
      GEST_DOWN  = 3'd1,
      GEST_LEFT  = 3'd2,
      GEST_RIGHT = 3'd3,
      GEST_CLICK = 3'd4
   } gesture_type;

   typedef struct packed {
      kind_type             kind;
      logic [COORD_W-1:0]   coord;
   } scaled_type;

endpackage

// ===== src/tsc_if.sv =====
// ----------------------------------------------------------------------------
// Touch swipe classifier channels
// Valid/ready interfaces for the event channel and the gesture channel.
// ----------------------------------------------------------------------------
interface tsc_req_if;
   logic                        valid;
   logic                        ready;
   logic [tsc_pkg::TYPE_W-1:0]  event_type;
   logic [tsc_pkg::CODE_W-1:0]  event_code;
   logic [tsc_pkg::RAW_W-1:0]   event_value;

   modport source (output valid, event_type, event_code, event_value, input ready);
   modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tsc_pkg::GEST_W-1:0]  gesture;

   modport source (output valid, gesture, input ready);
   modport sink   (input valid, gesture, output ready);
endinterface

// ===== src/tsc_scale.sv =====
// ----------------------------------------------------------------------------
// Touch swipe classifier event decode and scaling pipeline
// Registers each event, then scales axis values to screen pixels in two
// stages: a reciprocal estimate, then a one-step correction and saturation.
// ----------------------------------------------------------------------------
module tsc_scale (
   input  logic                clock,
   input  logic                reset,
   tsc_req_if.sink             req_bus,
   output logic                out_valid,
   output tsc_pkg::scaled_type out_item,
   input  logic                out_ready
);

   logic                           s0_valid_ff, s0_valid_in;
   tsc_pkg::kind_type              s0_kind_ff, s0_kind_in;
   logic [tsc_pkg::RAW_W-1:0]      s0_value_ff, s0_value_in;

   logic                           s1_valid_ff, s1_valid_in;
   tsc_pkg::kind_type              s1_kind_ff, s1_kind_in;
   logic                           s1_sat_ff, s1_sat_in;
   logic [tsc_pkg::COORD_W-1:0]    s1_quot_ff, s1_quot_in;
   logic [tsc_pkg::PROD_W-1:0]     s1_prod_ff, s1_prod_in;

   logic                           s2_valid_ff, s2_valid_in;
   tsc_pkg::scaled_type            s2_item_ff, s2_item_in;

   logic                           s0_free, s1_free, s2_free;
   tsc_pkg::kind_type              req_kind;

   logic                                       s1_is_y;
   logic [tsc_pkg::COORD_W-1:0]                s1_screen;
   logic [tsc_pkg::RECIP_W-1:0]                s1_recip;
   logic [tsc_pkg::RAW_W+tsc_pkg::RECIP_W-1:0] s1_est;
   logic [tsc_pkg::RECIP_W-1:0]                s1_qest;

   logic                            s2_is_y;
   logic [tsc_pkg::COORD_W-1:0]     s2_screen;
   logic [tsc_pkg::SPAN_W-1:0]      s2_span;
   logic [tsc_pkg::COORD_W:0]       s2_next;
   logic [tsc_pkg::COORD_W:0]       s2_quot;
   logic [tsc_pkg::TRIAL_W-1:0]     s2_trial;

   assign s2_free       = !s2_valid_ff || out_ready;
   assign s1_free       = !s1_valid_ff || s2_free;
   assign s0_free       = !s0_valid_ff || s1_free;
   assign req_bus.ready = s0_free;
   assign out_valid     = s2_valid_ff;
   assign out_item      = s2_item_ff;

   always_comb begin
      req_kind = tsc_pkg::KIND_NONE;
      if (req_bus.event_type == tsc_pkg::EVT_ABS && req_bus.event_code == tsc_pkg::CODE_X) begin
         req_kind = tsc_pkg::KIND_ABS_X;
      end else if (req_bus.event_type == tsc_pkg::EVT_ABS &&
                   req_bus.event_code == tsc_pkg::CODE_Y) begin
         req_kind = tsc_pkg::KIND_ABS_Y;
      end else if (req_bus.event_type == tsc_pkg::EVT_KEY &&
                   req_bus.event_code == tsc_pkg::CODE_TOUCH) begin
         if (req_bus.event_value == tsc_pkg::BTN_DOWN) begin
            req_kind = tsc_pkg::KIND_DOWN;
         end else if (req_bus.event_value == tsc_pkg::BTN_UP) begin
            req_kind = tsc_pkg::KIND_UP;
         end
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_kind_in  = s0_kind_ff;
      s0_value_in = s0_value_ff;
      if (s0_free) begin
         s0_valid_in = req_bus.valid;
         s0_kind_in  = req_kind;
         s0_value_in = req_bus.event_value;
      end
   end

   // Estimate from a truncated reciprocal; it is the true quotient or one less.
   always_comb begin
      s1_is_y    = (s0_kind_ff == tsc_pkg::KIND_ABS_Y);
      s1_screen  = s1_is_y ? tsc_pkg::SCREEN_HEIGHT : tsc_pkg::SCREEN_WIDTH;
      s1_recip   = s1_is_y ? tsc_pkg::RECIP_Y : tsc_pkg::RECIP_X;
      s1_est     = (tsc_pkg::RAW_W + tsc_pkg::RECIP_W)'(s0_value_ff) *
                   (tsc_pkg::RAW_W + tsc_pkg::RECIP_W)'(s1_recip);
      s1_qest    = s1_est[tsc_pkg::RECIP_SHIFT +: tsc_pkg::RECIP_W];
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_sat_in   = s1_sat_ff;
      s1_quot_in  = s1_quot_ff;
      s1_prod_in  = s1_prod_ff;
      if (s1_free) begin
         s1_valid_in = s0_valid_ff;
         s1_kind_in  = s0_kind_ff;
         s1_sat_in   = (s1_qest >= tsc_pkg::RECIP_W'(s1_screen));
         s1_quot_in  = s1_sat_in ? s1_screen : s1_qest[tsc_pkg::COORD_W-1:0];
         s1_prod_in  = tsc_pkg::PROD_W'(s0_value_ff) * tsc_pkg::PROD_W'(s1_screen);
      end
   end

   always_comb begin
      s2_is_y     = (s1_kind_ff == tsc_pkg::KIND_ABS_Y);
      s2_screen   = s2_is_y ? tsc_pkg::SCREEN_HEIGHT : tsc_pkg::SCREEN_WIDTH;
      s2_span     = s2_is_y ? tsc_pkg::RAW_Y_SPAN : tsc_pkg::RAW_X_SPAN;
      s2_next     = {1'b0, s1_quot_ff} + (tsc_pkg::COORD_W + 1)'(1);
      s2_trial    = tsc_pkg::TRIAL_W'(s2_next) * tsc_pkg::TRIAL_W'(s2_span);
      s2_quot     = (tsc_pkg::TRIAL_W'(s1_prod_ff) >= s2_trial) ? s2_next
                                                                 : {1'b0, s1_quot_ff};
      s2_valid_in = s2_valid_ff;
      s2_item_in  = s2_item_ff;
      if (s2_free) begin
         s2_valid_in      = s1_valid_ff;
         s2_item_in.kind  = s1_kind_ff;
         if (s1_sat_ff || s2_quot >= (tsc_pkg::COORD_W + 1)'(s2_screen)) begin
            s2_item_in.coord = s2_screen - tsc_pkg::COORD_W'(1);
         end else begin
            s2_item_in.coord = s2_quot[tsc_pkg::COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_kind_ff  <= s0_kind_in;
      s0_value_ff <= s0_value_in;
      s1_kind_ff  <= s1_kind_in;
      s1_sat_ff   <= s1_sat_in;
      s1_quot_ff  <= s1_quot_in;
      s1_prod_ff  <= s1_prod_in;
      s2_item_ff  <= s2_item_in;
   end

endmodule

// ===== src/tsc_classify.sv =====
// ----------------------------------------------------------------------------
// Touch swipe classifier position state and gesture decision
// Holds the current and start points and the threshold, and registers one
// gesture for every touch-up.
// ----------------------------------------------------------------------------
module tsc_classify (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tsc_pkg::THR_W-1:0]   csr_wdata,
   input  logic                        in_valid,
   input  tsc_pkg::scaled_type         in_item,
   output logic                        in_ready,
   tsc_rsp_if.source                   rsp_bus
);

   logic [tsc_pkg::THR_W-1:0]   thr_ff, thr_in;
   logic [tsc_pkg::X_W-1:0]     cur_x_ff, cur_x_in;
   logic [tsc_pkg::Y_W-1:0]     cur_y_ff, cur_y_in;
   logic [tsc_pkg::X_W-1:0]     start_x_ff, start_x_in;
   logic [tsc_pkg::Y_W-1:0]     start_y_ff, start_y_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tsc_pkg::gesture_type        gesture_ff, gesture_in;

   logic                        out_free;
   logic                        take;
   logic [tsc_pkg::X_W-1:0]     dx;
   logic [tsc_pkg::Y_W-1:0]     dy;
   tsc_pkg::gesture_type        decision;

   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign in_ready        = (in_item.kind != tsc_pkg::KIND_UP) || out_free;
   assign take            = in_valid && in_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.gesture = gesture_ff;

   always_comb begin
      dx = (cur_x_ff >= start_x_ff) ? cur_x_ff - start_x_ff : start_x_ff - cur_x_ff;
      dy = (cur_y_ff >= start_y_ff) ? cur_y_ff - start_y_ff : start_y_ff - cur_y_ff;
      if (dx > thr_ff || tsc_pkg::THR_W'(dy) > thr_ff) begin
         if (dx > tsc_pkg::X_W'(dy)) begin
            decision = (cur_x_ff > start_x_ff) ? tsc_pkg::GEST_RIGHT : tsc_pkg::GEST_LEFT;
         end else begin
            decision = (cur_y_ff > start_y_ff) ? tsc_pkg::GEST_DOWN : tsc_pkg::GEST_UP;
         end
      end else begin
         decision = tsc_pkg::GEST_CLICK;
      end
   end

   always_comb begin
      thr_in       = csr_we ? csr_wdata : thr_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      gesture_in   = gesture_ff;
      if (take) begin
         case (in_item.kind)
            tsc_pkg::KIND_ABS_X: begin
               cur_x_in = in_item.coord[tsc_pkg::X_W-1:0];
            end
            tsc_pkg::KIND_ABS_Y: begin
               cur_y_in = in_item.coord[tsc_pkg::Y_W-1:0];
            end
            tsc_pkg::KIND_DOWN: begin
               start_x_in = cur_x_ff;
               start_y_in = cur_y_ff;
            end
            tsc_pkg::KIND_UP: begin
               rsp_valid_in = 1'b1;
               gesture_in   = decision;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= tsc_pkg::THRESHOLD_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gesture_ff <= gesture_in;
   end

endmodule

// ===== src/touch_swipe_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Touch swipe classifier
// Turns a stream of touch-panel events into up, down, left, right or click.
//
// The req_bus channel takes one event per transaction: type, code and value.
// Absolute X and Y events are scaled to screen pixels and stored, touch-down
// latches the start point, and touch-up produces one gesture transaction on
// rsp_bus. All other events are absorbed without a result.
// The csr port writes the swipe threshold in pixels; write it only while no
// event is in flight.
// A touch-up event passes an input register, a reciprocal-multiply stage, a
// correction stage, and then the output register before its gesture is
// presented. One event is accepted every cycle while nothing stalls.
// When the receiver stalls, the gesture waits in the output register while
// events that produce no result keep flowing; a second touch-up waits in the
// correction stage, and req_bus.ready drops once the stages ahead are full.
// Reset empties the pipeline, clears all stored points to zero and sets the
// threshold to 50.
// ----------------------------------------------------------------------------
module touch_swipe_classifier_unit (
   input  logic                        clock,
   input  logic                        reset,
   tsc_req_if.sink                     req_bus,
   tsc_rsp_if.source                   rsp_bus,
   input  logic                        csr_we,
   input  logic [tsc_pkg::THR_W-1:0]   csr_wdata
);

   logic                 scaled_valid;
   logic                 scaled_ready;
   tsc_pkg::scaled_type  scaled_item;

   tsc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (scaled_valid),
      .out_item  (scaled_item),
      .out_ready (scaled_ready)
   );

   tsc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (scaled_valid),
      .in_item   (scaled_item),
      .in_ready  (scaled_ready),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_bus.ready)
      else $error("Event channel not ready after reset.");

   a_x_on_screen: assert property (@(posedge clock) disable iff (reset)
      (scaled_valid && scaled_item.kind == tsc_pkg::KIND_ABS_X)
         |-> (scaled_item.coord < tsc_pkg::SCREEN_WIDTH))
      else $error("Scaled X coordinate beyond the screen.");

   a_y_on_screen: assert property (@(posedge clock) disable iff (reset)
      (scaled_valid && scaled_item.kind == tsc_pkg::KIND_ABS_Y)
         |-> (scaled_item.coord < tsc_pkg::SCREEN_HEIGHT))
      else $error("Scaled Y coordinate beyond the screen.");

   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.gesture <= tsc_pkg::GEST_CLICK))
      else $error("Gesture transaction carries an undefined code.");
`endif

endmodule
